### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### hw/rtl/salru_pkg.sv
// Shared constants, types and helpers of the set-associative LRU tag lookup.
package salru_pkg;

	localparam int SET_COUNT_DEF   = 16;
	localparam int NUM_WAYS_DEF    = 4;
	localparam int BLOCK_BYTES_DEF = 64;

	localparam int ADDR_W    = 32;
	localparam int WAY_OUT_W = 2;
	localparam int COUNT_W   = 32;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} lkp_state_t;

	// Floor of log2, elaboration use only.
	function automatic int floor_log2(input int v);
		int n;
		int r;
		n = 0;
		r = v;
		for (int i = 0; i < 32; i++) begin
			if (r > 1) begin
				r = r >> 1;
				n++;
			end
		end
		return n;
	endfunction

endpackage

### hw/rtl/set_assoc_lru_tag_lookup.sv
// Top level of the set-associative tag lookup with true-LRU replacement.
`include "assert_macros.svh"

// Set-associative tag lookup with true-LRU replacement. Each transaction on
// the request channel carries one byte address; it is split into block
// offset, set index and tag, the tag is compared against every valid way of
// the set, and one response transaction returns hit, the way used (the way
// that hit or the way filled on a miss) and the wrapping access and hit
// totals including this lookup. Each set lives in one word of a synchronous
// set memory (tags, valid bits and LRU ranks side by side) with one read and
// one write port. A request is read from the set memory at the edge it is
// accepted; in the lookup stage the lookup, the victim choice and the rank
// update run, and when the stage advances the set word is written back
// while the result is loaded into the response register. The request is
// registered into the lookup stage and the result into the response
// register, and the sustained rate is one transaction per cycle while no
// response is stalled: a read of a set being written in the same cycle is
// forwarded from the write data. The response register stalls the lookup
// stage, and through it the request channel, only while a response waits
// and is stalled. After reset a clearing pass writes every set word, one
// set per cycle, so requests are stalled until the pass ends.
module set_assoc_lru_tag_lookup
	import salru_pkg::*;
#(
	parameter int SET_COUNT   = SET_COUNT_DEF,
	parameter int NUM_WAYS    = NUM_WAYS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [ADDR_W-1:0]    address,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 hit,
	output logic [WAY_OUT_W-1:0] way_used,
	output logic [COUNT_W-1:0]   access_total,
	output logic [COUNT_W-1:0]   hit_total
);

	localparam int OFF_W  = floor_log2(BLOCK_BYTES);
	localparam int IDX_W  = floor_log2(SET_COUNT);
	localparam int SET_AW = (IDX_W > 0) ? IDX_W : 1;
	localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
	localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam int WORD_W = NUM_WAYS * (TAG_W + 1 + RANK_W);

	localparam logic [SET_AW-1:0] SET_MASK = SET_AW'(SET_COUNT - 1);
	localparam logic [SET_AW-1:0] SET_LAST = SET_AW'(SET_COUNT - 1);
	localparam logic [RANK_W-1:0] RANK_MRU = RANK_W'(NUM_WAYS - 1);

	// Set memory: one word per set, {ranks, valid bits, tags}.
	logic [WORD_W-1:0] set_mem [SET_COUNT];

	lkp_state_t state_q, state_d;
	logic [SET_AW-1:0] clr_idx_q, clr_idx_d;
	logic clearing;

	logic req_acc;
	logic [SET_AW-1:0] req_idx;

	// Lookup stage.
	logic              valid_s1;
	logic [SET_AW-1:0] idx_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [WORD_W-1:0] rd_word_s1;
	logic              byp_s1;
	logic [WORD_W-1:0] byp_word_s1;
	logic              adv;

	// Write port.
	logic              wr_en;
	logic [SET_AW-1:0] wr_idx;
	logic [WORD_W-1:0] wr_word;

	// Response register and counters.
	logic                 rsp_valid_q;
	logic                 hit_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic [COUNT_W-1:0]   acc_q;
	logic [COUNT_W-1:0]   hits_q;

	// Lookup logic.
	logic [WORD_W-1:0]                set_word;
	logic [NUM_WAYS-1:0][RANK_W-1:0]  cur_rank, new_rank;
	logic [NUM_WAYS-1:0]              cur_valid, new_valid;
	logic [NUM_WAYS-1:0][TAG_W-1:0]   cur_tag, new_tag;
	logic [NUM_WAYS-1:0][RANK_W-1:0]  clr_rank;
	logic                             hit_c;
	logic                             inv_found;
	logic [WAY_W-1:0]                 hit_way, inv_way, lru_way, chosen;
	logic [RANK_W-1:0]                old_rank;
	logic [NUM_WAYS-1:0]              mru_vec;

	// Sequencer: clearing pass after reset, then normal operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q   <= state_d;
			clr_idx_q <= clr_idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_idx_d = clr_idx_q;
		clearing  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clearing  = 1'b1;
				clr_idx_d = clr_idx_q + SET_AW'(1);
				if (clr_idx_q == SET_LAST) begin
					state_d   = ST_RUN;
					clr_idx_d = '0;
				end
			end
			ST_RUN: begin
				clearing = 1'b0;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Handshake: advance the lookup stage when the response register is
	// free or being drained; take a request when the stage is free or
	// advancing.
	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = clearing || (valid_s1 && !adv);
	assign req_acc   = req_valid && !req_stall;
	assign req_idx   = SET_AW'(address >> OFF_W) & SET_MASK;

	// Set memory read, registered into the lookup stage.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			rd_word_s1 <= set_mem[req_idx];
		end
	end

	// Set memory write: clearing pass or lookup write-back.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			set_mem[wr_idx] <= wr_word;
		end
	end

	// Lookup stage registers. Capture the write data when the same set is
	// written at the edge of the read, since the read returns the old word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			idx_s1      <= req_idx;
			tag_s1      <= TAG_W'(address >> (OFF_W + IDX_W));
			byp_s1      <= wr_en && (wr_idx == req_idx);
			byp_word_s1 <= wr_word;
		end
	end

	// Tag compare, victim choice and rank update.
	always_comb begin
		set_word = byp_s1 ? byp_word_s1 : rd_word_s1;
		{cur_rank, cur_valid, cur_tag} = set_word;

		// Lowest matching way, lowest invalid way, way of rank zero.
		hit_c     = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		lru_way   = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (cur_valid[w] && (cur_tag[w] == tag_s1)) begin
				hit_c   = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!cur_valid[w]) begin
				inv_found = 1'b1;
				inv_way   = WAY_W'(w);
			end
			if (cur_rank[w] == '0) begin
				lru_way = WAY_W'(w);
			end
		end

		if (hit_c) begin
			chosen = hit_way;
		end else if (inv_found) begin
			chosen = inv_way;
		end else begin
			chosen = lru_way;
		end

		// Drop every rank above the chosen way's, then make it newest.
		old_rank  = cur_rank[chosen];
		new_valid = cur_valid;
		new_tag   = cur_tag;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (WAY_W'(w) == chosen) begin
				new_rank[w]  = RANK_MRU;
				new_valid[w] = 1'b1;
				if (!hit_c) begin
					new_tag[w] = tag_s1;
				end
			end else if (cur_rank[w] > old_rank) begin
				new_rank[w] = cur_rank[w] - RANK_W'(1);
			end else begin
				new_rank[w] = cur_rank[w];
			end
			mru_vec[w] = (new_rank[w] == RANK_MRU);
		end

		// Cleared word: all invalid, ranks in way order.
		for (int w = 0; w < NUM_WAYS; w++) begin
			clr_rank[w] = RANK_W'(w);
		end

		if (clearing) begin
			wr_en   = 1'b1;
			wr_idx  = clr_idx_q;
			wr_word = {clr_rank, {NUM_WAYS{1'b0}}, {(NUM_WAYS * TAG_W){1'b0}}};
		end else begin
			wr_en   = adv;
			wr_idx  = idx_s1;
			wr_word = {new_rank, new_valid, new_tag};
		end
	end

	// Response register and running totals. The totals only move when a
	// result is loaded, so they stand still while a response is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			acc_q       <= '0;
			hits_q      <= '0;
		end else begin
			if (adv) begin
				rsp_valid_q <= 1'b1;
				acc_q       <= acc_q + COUNT_W'(1);
				hits_q      <= hits_q + COUNT_W'(hit_c);
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= hit_c;
			way_q <= WAY_OUT_W'(chosen);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign hit          = hit_q;
	assign way_used     = way_q;
	assign access_total = acc_q;
	assign hit_total    = hits_q;

	`ASSERT_SAME(a_no_req_in_clear, clearing, req_stall, "request taken during clearing pass")
	`ASSERT_SAME(a_one_mru, adv && !clearing, $onehot(mru_vec), "rank update lost the single MRU way")
	`ASSERT_NEXT(a_adv_loads_rsp, adv, rsp_valid, "advanced lookup left no response")
	`ASSERT_NEXT(a_acc_step, adv, acc_q == $past(acc_q) + COUNT_W'(1), "access total did not step")
	`ASSERT_NEXT(a_hit_step, adv && hit_c, hits_q == $past(hits_q) + COUNT_W'(1), "hit total did not step")

endmodule
